>>> src/mlc_pkg.sv
// Shared types, character constants and the Greek name table for the label classifier.
package mlc_pkg;

    localparam int NUM_WORDS = 24;
    localparam int NAME_MAX  = 8;

    typedef logic [7:0]           byte_t;
    typedef logic [NUM_WORDS-1:0] name_vec_t;

    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_UP_A  = 8'h41;
    localparam byte_t CH_UP_Z  = 8'h5A;
    localparam byte_t CH_LO_A  = 8'h61;
    localparam byte_t CH_LO_Z  = 8'h7A;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_9     = 8'h39;
    localparam byte_t CASE_BIT = 8'h20;

    // Names are left-justified in 64 bits and padded with zero bytes.
    localparam logic [63:0] NAME_STR [NUM_WORDS] = '{
        {"alpha",   24'd0}, {"beta",    32'd0}, {"gamma",   24'd0}, {"delta",   24'd0},
        {"epsilon",  8'd0}, {"zeta",    32'd0}, {"eta",     40'd0}, {"theta",   24'd0},
        {"iota",    32'd0}, {"kappa",   24'd0}, {"lambda",  16'd0}, {"mu",      48'd0},
        {"nu",      48'd0}, {"xi",      48'd0}, {"omicron",  8'd0}, {"pi",      48'd0},
        {"rho",     40'd0}, {"sigma",   24'd0}, {"tau",     40'd0}, {"upsilon",  8'd0},
        {"phi",     40'd0}, {"chi",     40'd0}, {"psi",     40'd0}, {"omega",   24'd0}
    };

    localparam int NAME_LEN [NUM_WORDS] = '{
        5, 4, 5, 5, 7, 4, 3, 5, 4, 5, 6, 2, 2, 2, 7, 2, 3, 5, 3, 7, 3, 3, 3, 5
    };

    function automatic byte_t name_char(input int n, input int pos);
        byte_t c;
        c = '0;
        if (pos < NAME_MAX)
        begin
            c = NAME_STR[n][63 - 8*pos -: 8];
        end
        return c;
    endfunction

    // Names whose length is exactly len.
    function automatic name_vec_t name_len_mask(input int len);
        name_vec_t m;
        for (int n = 0; n < NUM_WORDS; n++)
        begin
            m[n] = (NAME_LEN[n] == len);
        end
        return m;
    endfunction

endpackage

>>> src/math_label_classifier_core.sv
// Top level of the label classifier: control, letter-run cells and result register.
//
// The classifier takes one label character per transaction and, on the transaction
// marked last (or flagged as an empty label), returns one is_expr verdict. A new
// character is taken in every cycle: a row of MAX_WORD cells, one per letter
// position, narrows the set of matching Greek names as the letters arrive, so
// the verdict needs no final compare pass. The verdict appears in the cycle after
// the last character is accepted and sits in an output register; input is
// stalled only while that register holds a verdict that has not been taken.
// Characters that produce no verdict are accepted whenever in_ready is high.
module math_label_classifier_core
    import mlc_pkg::*;
#(
    parameter int MAX_WORD = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] ch,
    input  logic       last,
    input  logic       empty_label,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_expr
);

    localparam int LEN_W = $clog2(MAX_WORD + 2);
    localparam int IDX_W = $clog2(MAX_WORD);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_WORD);
    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);

    logic             failed_reg, failed_next;
    logic             in_word_reg, in_word_next;
    logic [LEN_W-1:0] word_len_reg, word_len_next;
    logic [1:0]       char_seen_reg, char_seen_next;
    logic             first_space_reg, first_space_next;
    logic             out_valid_reg, out_valid_next;
    logic             is_expr_reg, is_expr_next;

    logic             accept;
    logic             letter;
    logic             digit;
    byte_t            ch_low;
    logic [LEN_W-1:0] len_base;
    logic [LEN_W-1:0] len_dec_cur;
    logic [LEN_W-1:0] len_dec_next;
    logic             run_ok_cur;
    logic             run_ok_next;
    logic             verdict;

    logic [MAX_WORD-1:0] cell_wr;
    logic [MAX_WORD-1:0] hit_reg;
    logic [MAX_WORD-1:0] hit_next;
    name_vec_t           match_chain [MAX_WORD+1];

    assign accept = in_valid && in_ready;
    assign ch_low = ch | CASE_BIT;
    assign letter = ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) ||
                    ((ch >= CH_LO_A) && (ch <= CH_LO_Z));
    assign digit  = (ch >= CH_0) && (ch <= CH_9);
    assign len_base = in_word_reg ? word_len_reg : '0;

    assign match_chain[0] = '1;

    genvar k;
    generate
        for (k = 0; k < MAX_WORD; k++)
        begin : g_cell
            assign cell_wr[k] = accept && !empty_label && letter &&
                                (len_base == LEN_W'(k));
            mlc_cell #(
                .POS (k)
            ) u_cell (
                .clk        (clk),
                .wr_en      (cell_wr[k]),
                .ch_low     (ch_low),
                .prev_match (match_chain[k]),
                .match_out  (match_chain[k+1]),
                .hit_reg    (hit_reg[k]),
                .hit_next   (hit_next[k])
            );
        end
    endgenerate

    always_comb
    begin
        failed_next      = failed_reg;
        in_word_next     = in_word_reg;
        word_len_next    = word_len_reg;
        char_seen_next   = char_seen_reg;
        first_space_next = first_space_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        is_expr_next     = is_expr_reg;

        len_dec_cur = word_len_reg - LEN_ONE;
        run_ok_cur  = !in_word_reg || (word_len_reg < LEN_TWO) ||
                      ((word_len_reg <= LEN_MAX) && hit_reg[len_dec_cur[IDX_W-1:0]]);

        // Run state after this character, used for the verdict.
        len_dec_next = '0;
        run_ok_next  = 1'b1;
        verdict      = 1'b0;

        if (accept)
        begin
            if (empty_label)
            begin
                out_valid_next   = 1'b1;
                is_expr_next     = 1'b0;
                failed_next      = 1'b0;
                in_word_next     = 1'b0;
                word_len_next    = '0;
                char_seen_next   = '0;
                first_space_next = 1'b0;
            end
            else
            begin
                if (char_seen_reg == 2'd0)
                begin
                    first_space_next = (ch == CH_SPACE);
                end
                if (char_seen_reg < 2'd2)
                begin
                    char_seen_next = char_seen_reg + 2'd1;
                end

                if (ch[7])
                begin
                    failed_next   = 1'b1;
                    in_word_next  = 1'b0;
                    word_len_next = '0;
                end
                else if (letter)
                begin
                    in_word_next  = 1'b1;
                    word_len_next = (len_base <= LEN_MAX) ? len_base + LEN_ONE : len_base;
                    len_dec_next  = word_len_next - LEN_ONE;
                    run_ok_next   = (word_len_next < LEN_TWO) ||
                                    ((word_len_next <= LEN_MAX) &&
                                     hit_next[len_dec_next[IDX_W-1:0]]);
                end
                else if (in_word_reg && digit)
                begin
                    failed_next   = 1'b1;
                    in_word_next  = 1'b0;
                    word_len_next = '0;
                end
                else
                begin
                    if (!run_ok_cur)
                    begin
                        failed_next = 1'b1;
                    end
                    in_word_next  = 1'b0;
                    word_len_next = '0;
                end

                verdict = !failed_next && run_ok_next &&
                          !((char_seen_next == 2'd1) && first_space_next);

                if (last)
                begin
                    out_valid_next   = 1'b1;
                    is_expr_next     = verdict;
                    failed_next      = 1'b0;
                    in_word_next     = 1'b0;
                    word_len_next    = '0;
                    char_seen_next   = '0;
                    first_space_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg      <= 1'b0;
            in_word_reg     <= 1'b0;
            word_len_reg    <= '0;
            char_seen_reg   <= '0;
            first_space_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            failed_reg      <= failed_next;
            in_word_reg     <= in_word_next;
            word_len_reg    <= word_len_next;
            char_seen_reg   <= char_seen_next;
            first_space_reg <= first_space_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_expr_reg <= is_expr_next;
    end

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign is_expr   = is_expr_reg;

`ifndef SYNTHESIS
    a_empty_gives_false: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty_label) |=> (out_valid && !is_expr))
        else $error("empty label did not produce a false verdict");

    a_high_byte_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !empty_label && last && ch[7]) |=> (out_valid && !is_expr))
        else $error("non-ASCII byte did not fail the label");

    a_len_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_word_reg |-> (word_len_reg == '0))
        else $error("letter count nonzero outside a run");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_len_reg <= LEN_MAX + LEN_ONE)
        else $error("letter count exceeded its saturation value");
`endif

endmodule

>>> src/mlc_cell.sv
// One letter position of the run: keeps the set of names that still match up to here.
module mlc_cell
    import mlc_pkg::*;
#(
    parameter int POS = 0
) (
    input  logic      clk,
    input  logic      wr_en,
    input  byte_t     ch_low,
    input  name_vec_t prev_match,
    output name_vec_t match_out,
    output logic      hit_reg,
    output logic      hit_next
);

    localparam name_vec_t LEN_MASK = name_len_mask(POS + 1);

    name_vec_t match_reg;
    name_vec_t match_next;
    name_vec_t eq;

    always_comb
    begin
        for (int n = 0; n < NUM_WORDS; n++)
        begin
            eq[n] = (ch_low == name_char(n, POS));
        end
        match_next = wr_en ? (prev_match & eq) : match_reg;
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign match_out = match_reg;
    assign hit_reg   = |(match_reg & LEN_MASK);
    assign hit_next  = |(match_next & LEN_MASK);

endmodule
